[rtl/drum_sample_voice_mixer_defines.svh]
// Assertion macros used by the checker file.
`ifndef DRUM_SAMPLE_VOICE_MIXER_DEFINES_SVH
`define DRUM_SAMPLE_VOICE_MIXER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define DSVM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define DSVM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/dsvm_pkg.sv]
package dsvm_pkg;

  // Request kinds carried in the input tuser
  typedef logic [1:0] req_t;
  localparam req_t REQ_MIDI = 2'd0;
  localparam req_t REQ_TICK = 2'd1;
  localparam req_t REQ_LOAD = 2'd2;

  // Instrument codes
  typedef logic [1:0] inst_t;
  localparam inst_t INST_SNARE = 2'd0;
  localparam inst_t INST_HIHAT = 2'd1;
  localparam inst_t INST_KICK  = 2'd2;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SNARE_LEN = 2'd0;
  localparam cfg_idx_t CFG_HIHAT_LEN = 2'd1;
  localparam cfg_idx_t CFG_KICK_LEN  = 2'd2;

  localparam int LEN_W  = 17;
  localparam int GAIN_W = 17;

  // MIDI decode
  localparam logic [3:0] STATUS_NOTE_ON = 4'h9;
  localparam logic [6:0] NOTE_SNARE     = 7'h24;
  localparam logic [6:0] NOTE_HIHAT     = 7'h26;
  localparam logic [6:0] NOTE_KICK      = 7'h28;

  // Velocity scale: vel/100 approximated as vel*655/65536
  localparam logic [GAIN_W-1:0] VEL_GAIN = 17'd655;
  localparam int GAIN_SHIFT = 16;

  // Per-voice control fields held in each cell
  typedef struct packed {
    logic       active;
    inst_t      inst;
    logic [6:0] vel;
  } voice_meta_t;

  // Control from the sequencer to the scale-and-accumulate pipeline
  typedef struct packed {
    logic              clear;
    logic              valid;
    inst_t             inst;
    logic [GAIN_W-1:0] gain;
  } mac_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_NOTE,
    S_TICK,
    S_DRAIN
  } state_t;

endpackage

[rtl/drum_sample_voice_mixer.sv]
// Frame tick: the voice cells pass the shared scaler one voice cell per cycle, and the result
// word is registered once the scaler drains and the output is free; no new word is accepted
// until then. Note-on: one ring rotation. Store load: written to its bank when accepted.
// Reset (rst_n low, synchronous) frees all voices and zeroes the length registers;
// the sample store is not cleared and holds garbage until loaded.
module drum_sample_voice_mixer #(
  parameter int MAX_VOICES   = 16,
  parameter int SAMPLE_DEPTH = 65536,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input words
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata, from bit 0: midi_status[7:0], midi_note[6:0], midi_velocity[6:0],
  // load_instrument[1:0], load_address[15:0], load_left[23:0], load_right[23:0]
  input  logic [87:0] in_tdata,
  // in_tuser: req_type[1:0]
  input  logic [1:0]  in_tuser,
  // Result words
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata, from bit 0: mix_left[23:0], mix_right[23:0], voices_busy[4:0], zero pad
  output logic [55:0] out_tdata,
  // Configuration writes
  input  logic        cfg_wr_en,
  input  dsvm_pkg::cfg_idx_t cfg_index,
  input  logic [16:0] cfg_wr_data
);
  import dsvm_pkg::*;

  localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
  localparam int POS_W  = (ADDR_W > 16) ? 16 : ADDR_W;
  localparam int IDX_W  = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int BUSY_W = $clog2(MAX_VOICES + 1);
  localparam int ACC_W  = SAMPLE_BITS + 2 + $clog2(MAX_VOICES + 1);
  localparam int DW     = 2 * SAMPLE_BITS;
  localparam logic [20:0]      DEPTH_W = 21'(SAMPLE_DEPTH);
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(SAMPLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_VOICES - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  // Input fields
  req_t        req_type;
  logic [7:0]  midi_status;
  logic [6:0]  midi_note;
  logic [6:0]  midi_velocity;
  inst_t       load_instrument;
  logic [15:0] load_address;
  logic [23:0] load_left, load_right;

  assign req_type        = in_tuser;
  assign midi_status     = in_tdata[7:0];
  assign midi_note       = in_tdata[14:8];
  assign midi_velocity   = in_tdata[21:15];
  assign load_instrument = in_tdata[23:22];
  assign load_address    = in_tdata[39:24];
  assign load_left       = in_tdata[63:40];
  assign load_right      = in_tdata[87:64];

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [BUSY_W-1:0] busy_r, busy_nxt;
  logic              placed_r, placed_nxt;
  inst_t             note_inst_r, note_inst_nxt;
  logic [6:0]        note_vel_r, note_vel_nxt;
  logic [LEN_W-1:0]  snare_len_r, hihat_len_r, kick_len_r;
  logic              out_valid_r, out_valid_nxt;
  logic [55:0]       out_data_r, out_data_nxt;

  logic              accept, note_hit, load_ok, shift_en, emit;
  inst_t             hit_inst;
  mac_ctl_t          ctl;
  logic              mac_busy;
  logic signed [ACC_W-1:0] acc_left, acc_right, sat_left, sat_right;

  // Voice ring
  voice_meta_t       meta_q [MAX_VOICES];
  logic [POS_W-1:0]  pos_q  [MAX_VOICES];
  voice_meta_t       head_meta, tail_meta;
  logic [POS_W-1:0]  head_pos, tail_pos;
  logic [LEN_W-1:0]  head_len, head_pos_ext, head_pos_inc;
  logic              contrib, still;

  assign accept = in_tvalid & in_tready;

  // Decode a drum note-on
  always_comb begin
    note_hit = 1'b0;
    hit_inst = INST_SNARE;
    if (midi_status[7:4] == STATUS_NOTE_ON && midi_velocity != 7'd0) begin
      case (midi_note)
        NOTE_SNARE: begin note_hit = 1'b1; hit_inst = INST_SNARE; end
        NOTE_HIHAT: begin note_hit = 1'b1; hit_inst = INST_HIHAT; end
        NOTE_KICK:  begin note_hit = 1'b1; hit_inst = INST_KICK;  end
        default:    note_hit = 1'b0;
      endcase
    end
  end

  assign load_ok = (req_type == REQ_LOAD) && (load_instrument != 2'd3)
                   && ({5'd0, load_address} < DEPTH_W);

  // Length registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snare_len_r <= '0;
      hihat_len_r <= '0;
      kick_len_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SNARE_LEN: snare_len_r <= cfg_wr_data;
        CFG_HIHAT_LEN: hihat_len_r <= cfg_wr_data;
        CFG_KICK_LEN:  kick_len_r  <= cfg_wr_data;
        default:       ;
      endcase
    end
  end

  // Length in effect for the head voice, capped at the store depth
  always_comb begin
    logic [LEN_W-1:0] raw;
    case (head_meta.inst)
      INST_SNARE: raw = snare_len_r;
      INST_HIHAT: raw = hihat_len_r;
      INST_KICK:  raw = kick_len_r;
      default:    raw = '0;
    endcase
    head_len = ({4'd0, raw} > DEPTH_W) ? LEN_CAP : raw;
  end

  // Head voice update: play one frame, free at the end of the sample
  assign head_meta    = meta_q[0];
  assign head_pos     = pos_q[0];
  assign head_pos_ext = LEN_W'(head_pos);
  assign head_pos_inc = head_pos_ext + 1'b1;
  assign contrib      = head_meta.active && (head_pos_ext < head_len);
  assign still        = contrib && (head_pos_inc < head_len);

  // Build the word that re-enters the ring at the tail
  always_comb begin
    tail_meta = head_meta;
    tail_pos  = head_pos;
    placed_nxt = placed_r;
    if (state_r == S_TICK) begin
      tail_meta.active = still;
      tail_pos         = POS_W'(head_pos_inc);
    end else if (state_r == S_NOTE && !placed_r && !head_meta.active) begin
      tail_meta.active = 1'b1;
      tail_meta.inst   = note_inst_r;
      tail_meta.vel    = note_vel_r;
      tail_pos         = '0;
      placed_nxt       = 1'b1;
    end
    if (state_r == S_IDLE) begin
      placed_nxt = 1'b0;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_VOICES; gi++) begin : g_cell
      voice_meta_t      cell_meta_in;
      logic [POS_W-1:0] cell_pos_in;
      if (gi == MAX_VOICES - 1) begin : g_tail
        assign cell_meta_in = tail_meta;
        assign cell_pos_in  = tail_pos;
      end else begin : g_mid
        assign cell_meta_in = meta_q[gi+1];
        assign cell_pos_in  = pos_q[gi+1];
      end
      dsvm_cell #(.POS_W(POS_W)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .meta_i   (cell_meta_in),
        .pos_i    (cell_pos_in),
        .meta_o   (meta_q[gi]),
        .pos_o    (pos_q[gi])
      );
    end
  endgenerate

  // Sample store, one bank per instrument
  logic [ADDR_W+15:0]  load_addr_ext;
  logic [ADDR_W-1:0]   waddr, raddr;
  logic [DW-1:0]       wdata;
  logic [DW-1:0]       rd_data [3];

  assign load_addr_ext = (ADDR_W + 16)'(load_address);
  assign waddr = load_addr_ext[ADDR_W-1:0];
  assign raddr = ADDR_W'(head_pos);
  assign wdata = {load_right[SAMPLE_BITS-1:0], load_left[SAMPLE_BITS-1:0]};

  generate
    for (gi = 0; gi < 3; gi++) begin : g_bank
      logic bank_we;
      assign bank_we = accept && load_ok && (load_instrument == inst_t'(gi));
      dsvm_ram #(.WIDTH(DW), .DEPTH(SAMPLE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (bank_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd_data[gi])
      );
    end
  endgenerate

  // Scale-and-accumulate pipeline
  dsvm_mac #(.SAMPLE_BITS(SAMPLE_BITS), .ACC_W(ACC_W)) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .rd_data   (rd_data),
    .acc_left  (acc_left),
    .acc_right (acc_right),
    .busy      (mac_busy)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && req_type == REQ_TICK) begin
          state_nxt = S_TICK;
        end else if (accept && req_type == REQ_MIDI && note_hit) begin
          state_nxt = S_NOTE;
        end
      end
      S_NOTE: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_TICK: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (emit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready = 1'b0;
    shift_en  = 1'b0;
    emit      = 1'b0;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        ctl.clear = accept && (req_type == REQ_TICK);
      end
      S_NOTE: begin
        shift_en = 1'b1;
      end
      S_TICK: begin
        shift_en  = 1'b1;
        ctl.valid = contrib;
        ctl.inst  = head_meta.inst;
        ctl.gain  = GAIN_W'(head_meta.vel) * VEL_GAIN;
      end
      S_DRAIN: begin
        emit = !mac_busy && (!out_valid_r || out_tready);
      end
      default: ;
    endcase
  end

  // Saturate the sums
  assign sat_left  = (acc_left > SAT_HI) ? SAT_HI : (acc_left < SAT_LO) ? SAT_LO : acc_left;
  assign sat_right = (acc_right > SAT_HI) ? SAT_HI :
                     (acc_right < SAT_LO) ? SAT_LO : acc_right;

  // Counters, captured note and result register
  always_comb begin
    logic [BUSY_W+4:0] busy_ext;
    idx_nxt       = (state_r == S_NOTE || state_r == S_TICK) ? idx_r + 1'b1 : '0;
    busy_nxt      = busy_r;
    note_inst_nxt = note_inst_r;
    note_vel_nxt  = note_vel_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    busy_ext      = (BUSY_W + 5)'(busy_r);
    if (state_r == S_IDLE && accept) begin
      busy_nxt      = '0;
      note_inst_nxt = hit_inst;
      note_vel_nxt  = midi_velocity;
    end
    if (state_r == S_TICK && still) begin
      busy_nxt = busy_r + 1'b1;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {3'd0, busy_ext[4:0], 24'(sat_right), 24'(sat_left)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      placed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      placed_r    <= placed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    busy_r      <= busy_nxt;
    note_inst_r <= note_inst_nxt;
    note_vel_r  <= note_vel_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[rtl/dsvm_ram.sv]
module dsvm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/dsvm_cell.sv]
module dsvm_cell #(
  parameter int POS_W = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 shift_en,
  input  dsvm_pkg::voice_meta_t meta_i,
  input  logic [POS_W-1:0]     pos_i,
  output dsvm_pkg::voice_meta_t meta_o,
  output logic [POS_W-1:0]     pos_o
);
  import dsvm_pkg::*;

  voice_meta_t      meta_r;
  logic [POS_W-1:0] pos_r;

  // Take the neighbor's voice on each shift; reset frees the voice
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r <= '0;
    end else if (shift_en) begin
      meta_r <= meta_i;
    end
  end

  // Position carries no reset
  always_ff @(posedge clk) begin
    if (shift_en) begin
      pos_r <= pos_i;
    end
  end

  assign meta_o = meta_r;
  assign pos_o  = pos_r;

endmodule

[rtl/dsvm_mac.sv]
module dsvm_mac #(
  parameter int SAMPLE_BITS = 24,
  parameter int ACC_W       = 31
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dsvm_pkg::mac_ctl_t          ctl,
  input  logic [2*SAMPLE_BITS-1:0]    rd_data [3],
  output logic signed [ACC_W-1:0]     acc_left,
  output logic signed [ACC_W-1:0]     acc_right,
  output logic                        busy
);
  import dsvm_pkg::*;

  localparam int PW = SAMPLE_BITS + GAIN_W + 1;

  logic                     v1_r;
  inst_t                    inst1_r;
  logic [GAIN_W-1:0]        gain1_r;
  logic                     v2_r;
  logic signed [PW-1:0]     p2l_r, p2r_r;
  logic signed [PW-1:0]     p2l_nxt, p2r_nxt;
  logic signed [ACC_W-1:0]  accl_r, accr_r;
  logic signed [ACC_W-1:0]  accl_nxt, accr_nxt;
  logic [2*SAMPLE_BITS-1:0] sel;
  logic signed [SAMPLE_BITS-1:0] smp_l, smp_r;
  logic signed [GAIN_W:0]   gain_s;
  logic signed [PW-1:0]     term_l, term_r;

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctl.valid;
      v2_r <= v1_r;
    end
  end

  // Stage 1: hold the voice fields while the store read completes
  always_ff @(posedge clk) begin
    inst1_r <= ctl.inst;
    gain1_r <= ctl.gain;
  end

  // Pick the word of the voice's instrument
  always_comb begin
    case (inst1_r)
      INST_SNARE: sel = rd_data[0];
      INST_HIHAT: sel = rd_data[1];
      INST_KICK:  sel = rd_data[2];
      default:    sel = '0;
    endcase
  end

  // Stage 2: scale both channels by the voice gain
  assign smp_l   = signed'(sel[SAMPLE_BITS-1:0]);
  assign smp_r   = signed'(sel[2*SAMPLE_BITS-1:SAMPLE_BITS]);
  assign gain_s  = signed'({1'b0, gain1_r});
  assign p2l_nxt = smp_l * gain_s;
  assign p2r_nxt = smp_r * gain_s;

  always_ff @(posedge clk) begin
    p2l_r <= p2l_nxt;
    p2r_r <= p2r_nxt;
  end

  // Stage 3: floor shift and accumulate
  assign term_l = p2l_r >>> GAIN_SHIFT;
  assign term_r = p2r_r >>> GAIN_SHIFT;

  always_comb begin
    accl_nxt = accl_r;
    accr_nxt = accr_r;
    if (ctl.clear) begin
      accl_nxt = '0;
      accr_nxt = '0;
    end else if (v2_r) begin
      accl_nxt = accl_r + ACC_W'(term_l);
      accr_nxt = accr_r + ACC_W'(term_r);
    end
  end

  always_ff @(posedge clk) begin
    accl_r <= accl_nxt;
    accr_r <= accr_nxt;
  end

  assign acc_left  = accl_r;
  assign acc_right = accr_r;
  assign busy      = v1_r | v2_r;

endmodule

[rtl/dsvm_checker.sv]
`include "drum_sample_voice_mixer_defines.svh"

module dsvm_checker #(
  parameter int MAX_VOICES = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);
  import dsvm_pkg::*;

  // A stalled result word holds
  `DSVM_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result word changed while stalled")

  // Reset empties the result register
  `DSVM_ASSERT_ALWAYS(a_reset_out, !rst_n |=> !out_tvalid, "result pending after reset")

  // Busy count never exceeds the voice count
  `DSVM_ASSERT(a_busy_max, out_tvalid |-> (MAX_VOICES >= 31) || (out_tdata[52:48] <= 5'(MAX_VOICES)), "busy count above voice count")

  // A frame tick keeps the input closed while the voices are swept
  `DSVM_ASSERT(a_tick_busy, in_tvalid && in_tready && in_tuser == REQ_TICK |=> !in_tready, "input open right after a tick")

endmodule

bind drum_sample_voice_mixer dsvm_checker #(.MAX_VOICES(MAX_VOICES)) u_dsvm_checker (.*);

[test/drum_sample_voice_mixer_tb.sv]
`timescale 1ns / 100ps

module drum_sample_voice_mixer_tb;
  import dsvm_pkg::*;

  localparam int MAX_VOICES = 16;
  localparam int DEPTH      = 65536;
  localparam int SETTLE     = MAX_VOICES + 24;
  localparam int WATCHDOG   = 3000;
  localparam int HOLD_LEN   = 300;

  localparam req_t     REQ_NONE  = 2'd3;
  localparam inst_t    INST_NONE = 2'd3;
  localparam cfg_idx_t CFG_SPARE = 2'd3;

  // One input word: the low 88 bits are the tdata layout, req_type on top
  typedef struct packed {
    req_t        req;
    logic [23:0] right;
    logic [23:0] left;
    logic [15:0] addr;
    inst_t       inst;
    logic [6:0]  vel;
    logic [6:0]  note;
    logic [7:0]  status;
  } in_word_t;

  // One result word, same layout as out_tdata[52:0]
  typedef struct packed {
    logic [4:0]  busy;
    logic [23:0] right;
    logic [23:0] left;
  } mix_t;

  typedef struct packed {
    in_word_t   w;
    logic [7:0] reps;
    bit         typed;
    mix_t       m;
  } row_t;

  typedef enum {PR_NONE, PR_HOLD, PR_PAUSE} press_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic [1:0]  in_tuser = REQ_MIDI;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  cfg_idx_t    cfg_index = CFG_SNARE_LEN;
  logic [16:0] cfg_wr_data = '0;

  drum_sample_voice_mixer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mirror of the mixer state
  logic signed [23:0] st_left  [0:3*DEPTH-1];
  logic signed [23:0] st_right [0:3*DEPTH-1];
  bit                 written  [0:3*DEPTH-1];
  bit                 v_active [0:MAX_VOICES-1];
  inst_t              v_inst   [0:MAX_VOICES-1];
  int                 v_pos    [0:MAX_VOICES-1];
  logic [6:0]         v_vel    [0:MAX_VOICES-1];
  int                 len_reg  [0:3];

  mix_t pending_mix[$];
  row_t dir_table[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_len    = 0;
  int mismatches  = 0;
  int stalled     = 0;
  int words_sent  = 0;
  int frames_seen = 0;
  int hits_taken  = 0;
  int hits_dropped = 0;
  int sat_count   = 0;
  int max_busy    = 0;
  int settings    = 0;

  function automatic int eff_len(inst_t i);
    return (len_reg[i] > DEPTH) ? DEPTH : len_reg[i];
  endfunction

  function automatic longint scaled(logic signed [23:0] s, logic [6:0] vel);
    longint p;
    p = longint'(s) * longint'(vel) * 655;
    return p >>> 16;
  endfunction

  function automatic logic [23:0] clip(longint v);
    if (v > 64'sd8388607) begin
      sat_count++;
      return 24'h7FFFFF;
    end
    if (v < -64'sd8388608) begin
      sat_count++;
      return 24'h800000;
    end
    return v[23:0];
  endfunction

  // Apply one accepted word to the mirror; returns 1 when a mix is due
  function automatic bit play_word(input in_word_t w, output mix_t m);
    longint sl;
    longint sr;
    int     busy;
    int     len;
    int     idx;
    int     slot;
    m = '0;
    sl = 0;
    sr = 0;
    busy = 0;
    slot = -1;
    case (w.req)
      REQ_MIDI: begin
        if (w.status[7:4] == STATUS_NOTE_ON && w.vel != 0 &&
            (w.note == NOTE_SNARE || w.note == NOTE_HIHAT || w.note == NOTE_KICK)) begin
          for (int i = 0; i < MAX_VOICES; i++)
            if (slot < 0 && !v_active[i]) slot = i;
          if (slot < 0) begin
            hits_dropped++;
          end else begin
            v_active[slot] = 1'b1;
            v_inst[slot] = (w.note == NOTE_SNARE) ? INST_SNARE :
                           (w.note == NOTE_HIHAT) ? INST_HIHAT : INST_KICK;
            v_pos[slot] = 0;
            v_vel[slot] = w.vel;
            hits_taken++;
          end
        end
        return 1'b0;
      end
      REQ_TICK: begin
        for (int i = 0; i < MAX_VOICES; i++) begin
          if (v_active[i]) begin
            len = eff_len(v_inst[i]);
            if (v_pos[i] >= len) begin
              // drop a voice whose length fell under its position
              v_active[i] = 1'b0;
            end else begin
              idx = int'(v_inst[i]) * DEPTH + v_pos[i];
              sl += scaled(st_left[idx], v_vel[i]);
              sr += scaled(st_right[idx], v_vel[i]);
              v_pos[i]++;
              if (v_pos[i] >= len) v_active[i] = 1'b0;
              else busy++;
            end
          end
        end
        m.left = clip(sl);
        m.right = clip(sr);
        m.busy = busy[4:0];
        if (busy > max_busy) max_busy = busy;
        return 1'b1;
      end
      REQ_LOAD: begin
        if (w.inst != INST_NONE) begin
          idx = int'(w.inst) * DEPTH + int'(w.addr);
          st_left[idx] = w.left;
          st_right[idx] = w.right;
          written[idx] = 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    w = {$urandom, $urandom, $urandom};
    return w;
  endfunction

  function automatic logic [23:0] rand_sample();
    logic [23:0] v;
    v = $urandom;
    case ($urandom_range(9))
      0: v = 24'h7FFFFF;
      1: v = 24'h800000;
      2, 3, 4: ;
      default: v = {{4{v[19]}}, v[19:0]};
    endcase
    return v;
  endfunction

  function automatic in_word_t mk_req(req_t r);
    in_word_t w;
    w = '0;
    w.req = r;
    return w;
  endfunction

  function automatic in_word_t mk_midi(logic [7:0] status, logic [6:0] note, logic [6:0] vel);
    in_word_t w;
    w = mk_req(REQ_MIDI);
    w.status = status;
    w.note = note;
    w.vel = vel;
    return w;
  endfunction

  function automatic in_word_t mk_load(inst_t inst, logic [15:0] addr,
                                       logic [23:0] l, logic [23:0] r);
    in_word_t w;
    w = mk_req(REQ_LOAD);
    w.inst = inst;
    w.addr = addr;
    w.left = l;
    w.right = r;
    return w;
  endfunction

  // Mostly well-formed hits, frames and loads; about one word in ten is noise
  function automatic in_word_t random_word(output bit noise);
    in_word_t w;
    int       pick;
    w = rand_word();
    noise = 1'b0;
    pick = $urandom_range(99);
    if (pick < 40) begin
      w.req = REQ_MIDI;
      w.status[7:4] = STATUS_NOTE_ON;
      w.vel = $urandom_range(127, 1);
      case ($urandom_range(2))
        0: w.note = NOTE_SNARE;
        1: w.note = NOTE_HIHAT;
        default: w.note = NOTE_KICK;
      endcase
    end else if (pick < 72) begin
      w.req = REQ_TICK;
    end else if (pick < 90) begin
      w.req = REQ_LOAD;
      w.inst = $urandom_range(2);
      if ($urandom_range(3) != 0) w.addr = $urandom_range(63);
      w.left = rand_sample();
      w.right = rand_sample();
    end else begin
      noise = 1'b1;
      case ($urandom_range(4))
        0: w.req = REQ_MIDI;
        1: begin
          w.req = REQ_MIDI;
          w.status[7:4] = STATUS_NOTE_ON;
          w.vel = '0;
        end
        2: begin
          w.req = REQ_MIDI;
          w.status[7:4] = STATUS_NOTE_ON;
        end
        3: w.req = REQ_NONE;
        default: begin
          w.req = REQ_LOAD;
          w.inst = INST_NONE;
        end
      endcase
    end
    return w;
  endfunction

  // Offer one word, hold it until accepted, then predict
  task automatic send_word(in_word_t w, bit typed, mix_t m);
    mix_t got;
    bit   has;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= w.req;
    in_tdata <= w[87:0];
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    has = play_word(w, got);
    if (has) begin
      pending_mix.push_back(typed ? m : got);
      frames_seen++;
    end
    words_sent++;
  endtask

  // Before a frame, load every entry an active voice is about to read
  task automatic fill_gaps();
    in_word_t ld;
    int       idx;
    for (int i = 0; i < MAX_VOICES; i++) begin
      if (v_active[i] && v_pos[i] < eff_len(v_inst[i])) begin
        idx = int'(v_inst[i]) * DEPTH + v_pos[i];
        if (!written[idx]) begin
          ld = rand_word();
          ld.req = REQ_LOAD;
          ld.inst = v_inst[i];
          ld.addr = v_pos[i];
          ld.left = rand_sample();
          ld.right = rand_sample();
          send_word(ld, 1'b0, '0);
        end
      end
    end
  endtask

  task automatic issue(in_word_t w, bit typed, mix_t m);
    if (w.req == REQ_TICK) fill_gaps();
    send_word(w, typed, m);
  endtask

  // Drop valid, wait for every mix due, then let the block settle
  task automatic quiesce(int extra);
    in_tvalid <= 1'b0;
    while (pending_mix.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [16:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    if (idx != CFG_SPARE) len_reg[idx] = val;
  endtask

  task automatic set_lengths(int s, int h, int k);
    quiesce(SETTLE);
    cfg_write(CFG_SNARE_LEN, s);
    cfg_write(CFG_HIHAT_LEN, h);
    cfg_write(CFG_KICK_LEN, k);
    cfg_write(CFG_SPARE, $urandom);
    cfg_wr_en <= 1'b0;
    settings++;
  endtask

  task automatic add_row(in_word_t w, int reps, bit typed,
                         logic [23:0] l, logic [23:0] r, logic [4:0] b);
    row_t row;
    row.w = w;
    row.reps = reps;
    row.typed = typed;
    row.m.left = l;
    row.m.right = r;
    row.m.busy = b;
    dir_table.push_back(row);
  endtask

  task automatic run_phase(int s, int h, int k, int tx, int rx, int count, press_t pr);
    in_word_t w;
    bit       noise;
    bit       pressed;
    int       n;
    set_lengths(s, h, k);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    pressed = 1'b0;
    n = 0;
    while (n < count) begin
      if (!pressed && n >= count / 2) begin
        pressed = 1'b1;
        case (pr)
          PR_HOLD: begin
            // stall the receiver long enough for the input to back up
            hold_len = HOLD_LEN;
            repeat (40) issue(mk_req(REQ_TICK), 1'b0, '0);
          end
          PR_PAUSE: quiesce(0);
          default: ;
        endcase
      end
      w = random_word(noise);
      issue(w, 1'b0, '0);
      if (!noise) n++;
    end
  endtask

  // Receiver: random stalls, or a long hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        out_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Compare each result word with the oldest mix due
  always @(posedge clk) begin : check_mix
    mix_t seen;
    mix_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen = out_tdata[52:0];
      if (pending_mix.size() == 0) begin
        $display("%0t: result word with no mix due, got %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = pending_mix.pop_front();
        if (seen.left !== want.left) begin
          $display("%0t: mix_left expected %h got %h", $time, want.left, seen.left);
          mismatches++;
        end
        if (seen.right !== want.right) begin
          $display("%0t: mix_right expected %h got %h", $time, want.right, seen.right);
          mismatches++;
        end
        if (seen.busy !== want.busy) begin
          $display("%0t: voices_busy expected %0d got %0d", $time, want.busy, seen.busy);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run after too many cycles with no handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      stalled <= 0;
    end else begin
      stalled <= stalled + 1;
      if (stalled >= WATCHDOG) begin
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG);
        $display("drum_sample_voice_mixer: mismatch");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: empty frame, full-scale samples, each instrument,
    // ignored messages, zero length, and a hit with every voice taken
    add_row(mk_req(REQ_TICK), 1, 1'b1, 24'h0, 24'h0, 5'd0);
    add_row(mk_load(INST_SNARE, 16'd0, 24'h7FFFFF, 24'h800000), 1, 1'b0, 0, 0, 0);
    add_row(mk_load(INST_SNARE, 16'd1, 24'hFFFFFF, 24'h000001), 1, 1'b0, 0, 0, 0);
    add_row(mk_load(INST_HIHAT, 16'd0, 24'd100, 24'hFFFF9C), 1, 1'b0, 0, 0, 0);
    add_row(mk_load(INST_KICK, 16'hFFFF, 24'h5A5A5A, 24'hA5A5A5), 1, 1'b0, 0, 0, 0);
    add_row(mk_load(INST_NONE, 16'd0, 24'h7FFFFF, 24'h7FFFFF), 1, 1'b0, 0, 0, 0);
    add_row(mk_midi(8'h99, NOTE_SNARE, 7'd127), 1, 1'b0, 0, 0, 0);
    add_row(mk_req(REQ_TICK), 1, 1'b1, 24'h7FFFFF, 24'h800000, 5'd1);
    add_row(mk_req(REQ_TICK), 1, 1'b0, 0, 0, 0);
    add_row(mk_midi(8'h90, NOTE_HIHAT, 7'd1), 1, 1'b0, 0, 0, 0);
    add_row(mk_req(REQ_TICK), 1, 1'b0, 0, 0, 0);
    add_row(mk_midi(8'h9F, NOTE_KICK, 7'd64), 1, 1'b0, 0, 0, 0);
    add_row(mk_req(REQ_TICK), 1, 1'b1, 24'h0, 24'h0, 5'd0);
    add_row(mk_midi(8'h90, NOTE_SNARE, 7'd0), 1, 1'b0, 0, 0, 0);
    // note-off status on a valid note
    add_row(mk_midi(8'h80, NOTE_SNARE, 7'd64), 1, 1'b0, 0, 0, 0);
    add_row(mk_midi(8'h90, 7'h25, 7'd64), 1, 1'b0, 0, 0, 0);
    add_row(mk_req(REQ_NONE), 1, 1'b0, 0, 0, 0);
    add_row(mk_req(REQ_TICK), 1, 1'b1, 24'h0, 24'h0, 5'd0);
    add_row(mk_midi(8'h9A, NOTE_SNARE, 7'd127), MAX_VOICES + 1, 1'b0, 0, 0, 0);
    add_row(mk_req(REQ_TICK), 1, 1'b1, 24'h7FFFFF, 24'h800000, MAX_VOICES);
    add_row(mk_req(REQ_TICK), 1, 1'b0, 0, 0, 0);

    set_lengths(2, 1, 0);
    foreach (dir_table[i])
      repeat (dir_table[i].reps) issue(dir_table[i].w, dir_table[i].typed, dir_table[i].m);

    // Random phases: each idling pattern, short and full-depth lengths
    run_phase(8, 3, 20, 0, 0, 250, PR_HOLD);
    run_phase(1, 0, 5, 48, 0, 250, PR_PAUSE);
    run_phase(65536, 131071, 12, 0, 48, 250, PR_NONE);
    run_phase(4, 2, 0, 38, 38, 250, PR_NONE);
    run_phase($urandom_range(24), $urandom_range(24), $urandom_range(24), 0, 0, 250,
              PR_NONE);

    quiesce(SETTLE);
    $display("ran %0d words over %0d length settings: %0d frames, %0d hits taken, %0d dropped",
             words_sent, settings, frames_seen, hits_taken, hits_dropped);
    $display("peak of %0d busy voices, %0d clipped channel sums", max_busy, sat_count);
    if (mismatches == 0) begin
      $display("drum_sample_voice_mixer: match");
    end else begin
      $display("drum_sample_voice_mixer: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/dsvm_pkg.sv
rtl/dsvm_ram.sv
rtl/dsvm_cell.sv
rtl/dsvm_mac.sv
rtl/drum_sample_voice_mixer.sv
rtl/dsvm_checker.sv
test/drum_sample_voice_mixer_tb.sv
